### hdl/slt_pkg.sv
// Shared widths, action and status codes, and the signed compare for the sorted table.
package slt_pkg;

    localparam int ACTION_W      = 3;
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 6;
    localparam int S_TDATA_W     = 32;
    localparam int S_TUSER_W     = 3;
    localparam int M_TDATA_W     = 40;
    localparam int M_TUSER_W     = 3;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [DATA_W-1:0]   data_t;

    localparam action_t ACT_CREATE  = 3'd0;
    localparam action_t ACT_INSERT  = 3'd1;
    localparam action_t ACT_DELETE  = 3'd2;
    localparam action_t ACT_SEARCH  = 3'd3;
    localparam action_t ACT_DISPLAY = 3'd4;

    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_NOT_FOUND   = 2'd1;
    localparam status_t ST_FULL        = 2'd2;
    localparam status_t ST_NOT_CREATED = 2'd3;

    // Signed order on raw 32-bit words
    function automatic logic less_than(input data_t a, input data_t b);
        less_than = ($signed(a) < $signed(b));
    endfunction

endpackage

### hdl/sorted_list_table.sv
// Sorted table of signed values held in a single-port-read, single-port-write memory.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser: action; s_tdata: operand_value
//  m_      | out | m_tvalid/m_tready  | m_tuser: status, item_valid; m_tdata: item_value,
//          |     | m_tlast = last     |   entry_count
//
// One request is worked at a time; s_tready is high only while the controller is idle.
// Create, refused actions and requests on an empty table: straight from idle to the result state.
// Insert: walks down from the tail, one memory read and shift write per cycle.
// Delete and search: one entry read per cycle from the memory port, over every entry.
// Display: one entry per cycle while m_tready is high; a low m_tready holds scan or result.
// Reset (aresetn low, synchronous) clears count and the created flag; memory is not cleared.
module sorted_list_table #(
    parameter int CAPACITY = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [slt_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] operand_value
    input  logic [slt_pkg::S_TUSER_W-1:0] s_tuser,  // [2:0] action
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [slt_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] item_value, [37:32] entry_count
    output logic [slt_pkg::M_TUSER_W-1:0] m_tuser,  // [1:0] status, [2] item_valid
    output logic                        m_tlast
);
    import slt_pkg::*;

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HEAD,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 created_reg, created_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]     wptr_reg, wptr_next;
    logic                 found_reg, found_next;
    action_t              op_reg, op_next;
    data_t                val_reg, val_next;
    status_t              status_reg, status_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    status_t              out_status_reg, out_status_next;
    data_t                out_value_reg, out_value_next;
    logic                 out_item_valid_reg, out_item_valid_next;
    logic                 out_last_reg, out_last_next;
    logic [CNT_W-1:0]     out_count_reg, out_count_next;

    // Memory port controls
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    data_t                rd_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    data_t                wr_data;
    data_t                mem [CAPACITY];

    logic                 slot_free;
    logic                 last_idx;
    logic                 match;
    action_t              in_action;
    data_t                in_value;

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {{(M_TDATA_W - DATA_W - ENTRY_COUNT_W){1'b0}},
                        ENTRY_COUNT_W'(out_count_reg), out_value_reg};
    assign m_tuser   = {out_item_valid_reg, out_status_reg};

    assign in_action = s_tuser[ACTION_W-1:0];
    assign in_value  = s_tdata[DATA_W-1:0];
    assign slot_free = !m_tvalid_reg || m_tready;
    assign last_idx  = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
    assign match     = (rd_data == val_reg);

    // Table storage: registered read, one write per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    // Sequencer: decode request, scan memory, build result
    always_comb begin
        state_next          = state_reg;
        count_next          = count_reg;
        created_next        = created_reg;
        idx_next            = idx_reg;
        wptr_next           = wptr_reg;
        found_next          = found_reg;
        op_next             = op_reg;
        val_next            = val_reg;
        status_next         = status_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        out_status_next     = out_status_reg;
        out_value_next      = out_value_reg;
        out_item_valid_next = out_item_valid_reg;
        out_last_next       = out_last_reg;
        out_count_next      = out_count_reg;
        rd_en               = 1'b0;
        rd_addr             = idx_reg;
        wr_en               = 1'b0;
        wr_addr             = idx_reg;
        wr_data             = val_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = in_action;
                    val_next    = in_value;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    wptr_next   = '0;
                    idx_next    = '0;
                    state_next  = S_RESP;
                    if (in_action == ACT_CREATE) begin
                        count_next   = '0;
                        created_next = 1'b1;
                    end else if (in_action > ACT_DISPLAY) begin
                        // unused code: plain acknowledge
                    end else if (!created_reg) begin
                        status_next = ST_NOT_CREATED;
                    end else begin
                        case (in_action)
                            ACT_INSERT: begin
                                if (count_reg >= CNT_W'(CAPACITY)) begin
                                    status_next = ST_FULL;
                                end else if (count_reg == '0) begin
                                    wr_en      = 1'b1;
                                    wr_addr    = '0;
                                    wr_data    = in_value;
                                    count_next = CNT_W'(1);
                                end else begin
                                    // start from the tail and shift upward
                                    rd_en      = 1'b1;
                                    rd_addr    = AW'(count_reg - CNT_W'(1));
                                    idx_next   = AW'(count_reg - CNT_W'(1));
                                    state_next = S_SCAN;
                                end
                            end
                            ACT_DELETE, ACT_SEARCH: begin
                                if (count_reg == '0) begin
                                    status_next = ST_NOT_FOUND;
                                end else begin
                                    rd_en      = 1'b1;
                                    rd_addr    = '0;
                                    state_next = S_SCAN;
                                end
                            end
                            default: begin
                                // display
                                if (count_reg != '0) begin
                                    rd_en      = 1'b1;
                                    rd_addr    = '0;
                                    state_next = S_SCAN;
                                end
                            end
                        endcase
                    end
                end
            end

            S_SCAN: begin
                case (op_reg)
                    ACT_INSERT: begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg + AW'(1);
                        if (less_than(rd_data, val_reg)) begin
                            // slot found just above this entry
                            wr_data    = val_reg;
                            count_next = count_reg + CNT_W'(1);
                            state_next = S_RESP;
                        end else begin
                            wr_data = rd_data;
                            if (idx_reg == '0) begin
                                state_next = S_HEAD;
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = idx_reg - AW'(1);
                                idx_next = idx_reg - AW'(1);
                            end
                        end
                    end
                    ACT_DELETE: begin
                        // compact kept entries down to the write pointer
                        if (match) begin
                            found_next = 1'b1;
                        end else begin
                            wr_en     = 1'b1;
                            wr_addr   = wptr_reg[AW-1:0];
                            wr_data   = rd_data;
                            wptr_next = wptr_reg + CNT_W'(1);
                        end
                        if (last_idx) begin
                            count_next  = match ? wptr_reg : (wptr_reg + CNT_W'(1));
                            status_next = (found_reg || match) ? ST_OK : ST_NOT_FOUND;
                            state_next  = S_RESP;
                        end else begin
                            rd_en    = 1'b1;
                            rd_addr  = idx_reg + AW'(1);
                            idx_next = idx_reg + AW'(1);
                        end
                    end
                    ACT_SEARCH: begin
                        if (match) begin
                            found_next = 1'b1;
                        end
                        if (last_idx) begin
                            status_next = (found_reg || match) ? ST_OK : ST_NOT_FOUND;
                            state_next  = S_RESP;
                        end else begin
                            rd_en    = 1'b1;
                            rd_addr  = idx_reg + AW'(1);
                            idx_next = idx_reg + AW'(1);
                        end
                    end
                    ACT_DISPLAY: begin
                        // hold the read data until the output slot frees
                        if (slot_free) begin
                            m_tvalid_next       = 1'b1;
                            out_status_next     = ST_OK;
                            out_value_next      = rd_data;
                            out_item_valid_next = 1'b1;
                            out_last_next       = last_idx;
                            out_count_next      = count_reg;
                            if (last_idx) begin
                                state_next = S_IDLE;
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = idx_reg + AW'(1);
                                idx_next = idx_reg + AW'(1);
                            end
                        end
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_HEAD: begin
                // new value becomes the smallest entry
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_RESP;
            end

            S_RESP: begin
                if (slot_free) begin
                    m_tvalid_next       = 1'b1;
                    out_status_next     = status_reg;
                    out_value_next      = '0;
                    out_item_valid_next = 1'b0;
                    out_last_next       = 1'b1;
                    out_count_next      = count_reg;
                    state_next          = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            created_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            created_reg  <= created_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg            <= idx_next;
        wptr_reg           <= wptr_next;
        found_reg          <= found_next;
        op_reg             <= op_next;
        val_reg            <= val_next;
        status_reg         <= status_next;
        out_status_reg     <= out_status_next;
        out_value_reg      <= out_value_next;
        out_item_valid_reg <= out_item_valid_next;
        out_last_reg       <= out_last_next;
        out_count_reg      <= out_count_next;
    end

endmodule

### test/table_result_checker.sv
// Result checker for the sorted table: tracks the table from accepted requests and checks each result.
module table_result_checker #(
    parameter int CAPACITY = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [slt_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] operand_value
    input  logic [slt_pkg::S_TUSER_W-1:0] s_tuser,   // [2:0] action
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [slt_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] item_value, [37:32] entry_count
    input  logic [slt_pkg::M_TUSER_W-1:0] m_tuser,   // [1:0] status, [2] item_valid
    input  logic                          m_tlast,
    output int                            fail_count,
    output int                            pending_results
);

    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    typedef logic [ENTRY_COUNT_W-1:0] entry_count_t;

    typedef struct packed {
        status_t      status;
        data_t        item_value;
        logic         item_valid;
        logic         last_flag;
        entry_count_t entry_count;
    } table_result_t;

    // Shadow copy of the table contents
    data_t table_entries [CAPACITY];
    int    table_count;
    bit    table_created;

    table_result_t expected_results [$];
    int            mismatches;

    initial begin
        fail_count      = 0;
        pending_results = 0;
        mismatches      = 0;
        table_count     = 0;
        table_created   = 1'b0;
    end

    // Queue a single closing result that carries no entry
    function automatic void expect_summary(input status_t st);
        expected_results.push_back('{status: st, item_value: '0, item_valid: 1'b0,
                                     last_flag: 1'b1,
                                     entry_count: entry_count_t'(table_count)});
    endfunction

    // Advance the shadow table by one request and queue the results it causes
    function automatic void predict_table_action(input action_t act, input data_t val);
        int pos;
        int kept;
        bit hit;
        pos  = 0;
        kept = 0;
        hit  = 1'b0;
        if (act > ACT_DISPLAY) begin
            expect_summary(ST_OK);
        end else if (act == ACT_CREATE) begin
            table_count   = 0;
            table_created = 1'b1;
            expect_summary(ST_OK);
        end else if (!table_created) begin
            expect_summary(ST_NOT_CREATED);
        end else begin
            case (act)
                ACT_INSERT: begin
                    if (table_count >= CAPACITY) begin
                        expect_summary(ST_FULL);
                    end else begin
                        // place in front of the first entry that is not smaller
                        while (pos < table_count && $signed(table_entries[pos]) < $signed(val))
                            pos++;
                        for (int i = table_count; i > pos; i--)
                            table_entries[i] = table_entries[i-1];
                        table_entries[pos] = val;
                        table_count++;
                        expect_summary(ST_OK);
                    end
                end
                ACT_DELETE: begin
                    // drop every equal entry and close the gaps
                    for (int i = 0; i < table_count; i++) begin
                        if (table_entries[i] == val)
                            hit = 1'b1;
                        else begin
                            table_entries[kept] = table_entries[i];
                            kept++;
                        end
                    end
                    table_count = kept;
                    expect_summary(hit ? ST_OK : ST_NOT_FOUND);
                end
                ACT_SEARCH: begin
                    for (int i = 0; i < table_count; i++)
                        if (table_entries[i] == val)
                            hit = 1'b1;
                    expect_summary(hit ? ST_OK : ST_NOT_FOUND);
                end
                default: begin
                    if (table_count == 0) begin
                        expect_summary(ST_OK);
                    end else begin
                        for (int i = 0; i < table_count; i++)
                            expected_results.push_back('{status: ST_OK,
                                item_value: table_entries[i], item_valid: 1'b1,
                                last_flag: (i == table_count - 1),
                                entry_count: entry_count_t'(table_count)});
                    end
                end
            endcase
        end
    endfunction

    // Compare one accepted result with the oldest expectation
    function automatic void check_table_result();
        table_result_t got;
        table_result_t want;
        got = '{status: m_tuser[1:0], item_value: m_tdata[31:0], item_valid: m_tuser[2],
                last_flag: m_tlast, entry_count: m_tdata[37:32]};
        if (expected_results.size() == 0) begin
            $error("result with no request pending: status %0d item_value %0h",
                   got.status, got.item_value);
            mismatches++;
            return;
        end
        want = expected_results.pop_front();
        if (got.status != want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
        end
        if (got.item_value != want.item_value) begin
            $error("item_value mismatch: expected %0h, actual %0h",
                   want.item_value, got.item_value);
            mismatches++;
        end
        if (got.item_valid != want.item_valid) begin
            $error("item_valid mismatch: expected %0d, actual %0d",
                   want.item_valid, got.item_valid);
            mismatches++;
        end
        if (got.last_flag != want.last_flag) begin
            $error("last mismatch: expected %0d, actual %0d", want.last_flag, got.last_flag);
            mismatches++;
        end
        if (got.entry_count != want.entry_count) begin
            $error("entry_count mismatch: expected %0d, actual %0d",
                   want.entry_count, got.entry_count);
            mismatches++;
        end
    endfunction

    // Check results first, then predict from the request accepted at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            table_count   = 0;
            table_created = 1'b0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_table_result();
            if (s_tvalid && s_tready)
                predict_table_action(action_t'(s_tuser), data_t'(s_tdata));
        end
        fail_count      <= mismatches;
        pending_results <= expected_results.size();
    end

endmodule

### test/tb_sorted_list_table.sv
// Testbench top for the sorted table: clock, reset, request stimulus, watchdog and verdict.
module tb_sorted_list_table;

    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int TOTAL_ITEMS  = 170;
    localparam int POOL_MAX     = 48;

    // Action codes the block ignores
    localparam action_t ACT_SPARE_LO = ACT_DISPLAY + 3'd1;
    localparam action_t ACT_SPARE_HI = '1;

    localparam data_t MOST_NEGATIVE = 32'h8000_0000;
    localparam data_t MOST_POSITIVE = 32'h7FFF_FFFF;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    int    fail_count;
    int    pending_results;
    int    requests_sent = 0;
    int    quiet_cycles  = 0;
    logic  idle_on       = 1'b1;
    data_t value_pool [$];

    sorted_list_table #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    table_result_checker #(
        .CAPACITY(TABLE_DEPTH)
    ) result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_tready <= !(idle_on && $urandom_range(99) < 7);
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sorted_list_table verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request and hold it until accepted
    task automatic send_request(input action_t act, input data_t val);
        if (idle_on && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 30)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        // keep a quiet stretch in the middle of the run
        idle_on <= !(requests_sent >= 90 && requests_sent < 130);
        if (act == ACT_INSERT) begin
            value_pool.push_back(val);
            if (value_pool.size() > POOL_MAX)
                void'(value_pool.pop_front());
        end
    endtask

    // Favor values already inserted so deletes and searches hit
    function automatic data_t pick_operand();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50 && value_pool.size() != 0)
            return value_pool[$urandom_range(value_pool.size() - 1)];
        if (roll < 70)
            return data_t'($urandom_range(16)) - data_t'(8);
        if (roll < 78)
            return $urandom_range(1) ? MOST_NEGATIVE : MOST_POSITIVE;
        return data_t'($urandom());
    endfunction

    initial begin
        int unsigned roll;
        int          ops;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: before create, empty table, extremes, duplicates, spare codes
        send_request(ACT_INSERT, 32'd5);
        send_request(ACT_DELETE, 32'd5);
        send_request(ACT_SEARCH, 32'd5);
        send_request(ACT_DISPLAY, '0);
        send_request(ACT_SPARE_LO, '0);
        send_request(ACT_CREATE, data_t'($urandom()));
        send_request(ACT_DISPLAY, '0);
        send_request(ACT_SEARCH, '0);
        send_request(ACT_DELETE, '0);
        send_request(ACT_INSERT, MOST_POSITIVE);
        send_request(ACT_INSERT, MOST_NEGATIVE);
        send_request(ACT_INSERT, '0);
        send_request(ACT_INSERT, '1);
        send_request(ACT_INSERT, 32'd1);
        send_request(ACT_INSERT, 32'd5);
        send_request(ACT_INSERT, 32'd5);
        send_request(ACT_SEARCH, MOST_NEGATIVE);
        send_request(ACT_SEARCH, 32'd2);
        send_request(ACT_DELETE, 32'd5);
        send_request(ACT_DELETE, 32'd5);
        send_request(ACT_SPARE_LO + 3'd1, '1);
        send_request(ACT_DISPLAY, '0);
        send_request(ACT_CREATE, '0);
        send_request(ACT_SPARE_HI, data_t'($urandom()));
        send_request(ACT_DISPLAY, '0);

        // Fill the table past capacity, then probe and trim it
        send_request(ACT_CREATE, data_t'($urandom()));
        repeat (TABLE_DEPTH + 2)
            send_request(ACT_INSERT, pick_operand());
        send_request(ACT_DISPLAY, data_t'($urandom()));
        repeat (3) send_request(ACT_SEARCH, pick_operand());
        repeat (3) send_request(ACT_DELETE, pick_operand());
        send_request(ACT_DISPLAY, '0);

        // Random sessions of mixed requests
        while (requests_sent < TOTAL_ITEMS) begin
            if ($urandom_range(1))
                send_request(ACT_CREATE, data_t'($urandom()));
            ops = $urandom_range(14, 4);
            repeat (ops) begin
                roll = $urandom_range(99);
                if (roll < 45)
                    send_request(ACT_INSERT, pick_operand());
                else if (roll < 62)
                    send_request(ACT_DELETE, pick_operand());
                else if (roll < 80)
                    send_request(ACT_SEARCH, pick_operand());
                else if (roll < 92)
                    send_request(ACT_DISPLAY, data_t'($urandom()));
                else if (roll < 95)
                    send_request(ACT_CREATE, data_t'($urandom()));
                else
                    send_request(action_t'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)),
                                 data_t'($urandom()));
            end
        end

        // Drain the result channel, then let the block settle
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_results == 0)
            $display("sorted_list_table verification clean");
        else
            $display("sorted_list_table verification failed");
        $finish;
    end

endmodule
